// File: hdl/vau_pkg.sv
`default_nettype none

package vau_pkg;

  localparam int DataWidthDef = 16;
  localparam int VecLen       = 3;

  typedef enum logic [2:0] {
    CMD_CROSS = 3'd0,
    CMD_DOT   = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_DIV   = 3'd5,
    CMD_EQ    = 3'd6,
    CMD_ZERO  = 3'd7
  } cmd_e;

  // Per-lane status that travels with the data through the lane pipeline
  typedef struct packed {
    cmd_e cmd;
    logic div_zero;
    logic eq;
    logic zero;
  } lane_flags_t;

endpackage

`default_nettype wire

// File: hdl/vau_lane.sv
`default_nettype none

// One vector component: multipliers and add/sub in the first stage, then a
// restoring divider that resolves one quotient bit per stage.
module vau_lane #(
  parameter int DATA_WIDTH = vau_pkg::DataWidthDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire vau_pkg::cmd_e           cmd_i,
  input  wire logic [DATA_WIDTH-1:0]   a_c_i,
  input  wire logic [DATA_WIDTH-1:0]   a_n_i,
  input  wire logic [DATA_WIDTH-1:0]   a_p_i,
  input  wire logic [DATA_WIDTH-1:0]   b_c_i,
  input  wire logic [DATA_WIDTH-1:0]   b_n_i,
  input  wire logic [DATA_WIDTH-1:0]   b_p_i,
  input  wire logic [DATA_WIDTH-1:0]   scalar_i,
  output logic [DATA_WIDTH-1:0]        res_o,
  output logic [DATA_WIDTH-1:0]        dot_term_o,
  output vau_pkg::lane_flags_t         flags_o
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] mul_m;
  logic [W-1:0] mul_n;
  logic [W-1:0] mul_d;
  logic [W-1:0] mul_m_a;
  logic [W-1:0] mul_m_b;

  logic [W-1:0]         pm_q;
  logic [W-1:0]         pn_q;
  logic [W-1:0]         pd_q;
  logic [W-1:0]         as_q;
  logic [W-1:0]         num1_q;
  logic [W-1:0]         den1_q;
  logic                 neg1_q;
  vau_pkg::lane_flags_t flags1_q;
  logic [W-1:0]         vec1;

  logic [W-1:0]         rem_q   [W];
  logic [W-1:0]         num_q   [W];
  logic [W-1:0]         quo_q   [W];
  logic [W-1:0]         den_q   [W];
  logic [W-1:0]         vec_q   [W];
  logic [W-1:0]         dot_q   [W];
  logic                 neg_q   [W];
  vau_pkg::lane_flags_t flags_q [W];

  logic [W-1:0] quo_signed;

  // Scale and the first cross term share one multiplier
  assign mul_m_a = (cmd_i == vau_pkg::CMD_SCALE) ? a_c_i : a_n_i;
  assign mul_m_b = (cmd_i == vau_pkg::CMD_SCALE) ? scalar_i : b_p_i;
  assign mul_m   = mul_m_a * mul_m_b;
  assign mul_n   = a_p_i * b_n_i;
  assign mul_d   = a_c_i * b_c_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q            <= mul_m;
      pn_q            <= mul_n;
      pd_q            <= mul_d;
      as_q            <= (cmd_i == vau_pkg::CMD_SUB) ? (a_c_i - b_c_i) : (a_c_i + b_c_i);
      num1_q          <= a_c_i[W-1] ? (~a_c_i + 1'b1) : a_c_i;
      den1_q          <= scalar_i[W-1] ? (~scalar_i + 1'b1) : scalar_i;
      neg1_q          <= a_c_i[W-1] ^ scalar_i[W-1];
      flags1_q.cmd      <= cmd_i;
      flags1_q.div_zero <= (scalar_i == '0);
      flags1_q.eq       <= (a_c_i == b_c_i);
      flags1_q.zero     <= (a_c_i == '0);
    end
  end

  always_comb begin
    case (flags1_q.cmd)
      vau_pkg::CMD_CROSS: vec1 = pm_q - pn_q;
      vau_pkg::CMD_SCALE: vec1 = pm_q;
      vau_pkg::CMD_ADD,
      vau_pkg::CMD_SUB:   vec1 = as_q;
      default:            vec1 = '0;
    endcase
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W-1:0]         rem_in;
    logic [W-1:0]         num_in;
    logic [W-1:0]         quo_in;
    logic [W-1:0]         den_in;
    logic [W-1:0]         vec_in;
    logic [W-1:0]         dot_in;
    logic                 neg_in;
    vau_pkg::lane_flags_t flags_in;
    logic [W:0]           trial;
    logic [W:0]           diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign rem_in   = '0;
      assign num_in   = num1_q;
      assign quo_in   = '0;
      assign den_in   = den1_q;
      assign vec_in   = vec1;
      assign dot_in   = pd_q;
      assign neg_in   = neg1_q;
      assign flags_in = flags1_q;
    end else begin : g_next
      assign rem_in   = rem_q[s-1];
      assign num_in   = num_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign den_in   = den_q[s-1];
      assign vec_in   = vec_q[s-1];
      assign dot_in   = dot_q[s-1];
      assign neg_in   = neg_q[s-1];
      assign flags_in = flags_q[s-1];
    end

    // Bring down the next dividend bit and try the subtract
    assign trial = {rem_in, num_in[W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]   <= ge ? diff[W-1:0] : trial[W-1:0];
        num_q[s]   <= {num_in[W-2:0], 1'b0};
        quo_q[s]   <= {quo_in[W-2:0], ge};
        den_q[s]   <= den_in;
        vec_q[s]   <= vec_in;
        dot_q[s]   <= dot_in;
        neg_q[s]   <= neg_in;
        flags_q[s] <= flags_in;
      end
    end
  end

  assign quo_signed = neg_q[W-1] ? (~quo_q[W-1] + 1'b1) : quo_q[W-1];

  always_comb begin
    if (flags_q[W-1].cmd == vau_pkg::CMD_DIV) begin
      res_o = flags_q[W-1].div_zero ? '0 : quo_signed;
    end else begin
      res_o = vec_q[W-1];
    end
  end

  assign dot_term_o = dot_q[W-1];
  assign flags_o    = flags_q[W-1];

endmodule

`default_nettype wire

// File: hdl/vau_merge.sv
`default_nettype none

// Combine the three lanes into one result beat and hold it in the output register.
module vau_merge #(
  parameter int DATA_WIDTH = vau_pkg::DataWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [DATA_WIDTH-1:0] res_i      [vau_pkg::VecLen],
  input  wire logic [DATA_WIDTH-1:0] dot_term_i [vau_pkg::VecLen],
  input  wire vau_pkg::lane_flags_t  flags_i    [vau_pkg::VecLen],
  output logic [DATA_WIDTH-1:0]      r_o        [vau_pkg::VecLen],
  output logic [DATA_WIDTH-1:0]      dot_value_o,
  output logic                       test_flag_o,
  output logic                       divide_error_o
);

  vau_pkg::cmd_e         cmd;
  logic [DATA_WIDTH-1:0] dot_sum;
  logic                  all_eq;
  logic                  all_zero;
  logic                  test_d;

  assign cmd = flags_i[0].cmd;

  always_comb begin
    dot_sum  = '0;
    all_eq   = 1'b1;
    all_zero = 1'b1;
    for (int i = 0; i < vau_pkg::VecLen; i++) begin
      dot_sum  = dot_sum + dot_term_i[i];
      all_eq   = all_eq & flags_i[i].eq;
      all_zero = all_zero & flags_i[i].zero;
    end
  end

  always_comb begin
    case (cmd)
      vau_pkg::CMD_EQ:   test_d = all_eq;
      vau_pkg::CMD_ZERO: test_d = all_zero;
      default:           test_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o            <= res_i;
      dot_value_o    <= (cmd == vau_pkg::CMD_DOT) ? dot_sum : '0;
      test_flag_o    <= test_d;
      divide_error_o <= (cmd == vau_pkg::CMD_DIV) && flags_i[0].div_zero;
    end
  end

endmodule

`default_nettype wire

// File: hdl/vector3_integer_alu.sv
`default_nettype none

// Three-component integer vector ALU. Each input beat carries a command, two
// signed vectors a and b and a signed scalar; each beat produces exactly one
// output beat holding a result vector, a dot product, a test flag and a
// divide-error flag, all wrapped to DATA_WIDTH bits. Three lanes, one per
// component, run in parallel. The block takes one beat every cycle unless
// back-pressure holds it; its pipeline is one stage of multipliers, then the
// divider, which resolves one quotient bit per stage, then the output
// register. The whole pipeline advances whenever the output register is
// empty or being read, so back-pressure stalls it in place.
// Divide truncates toward zero; a zero divisor returns the zero vector with
// divide_error set.
module vector3_integer_alu #(
  parameter int DATA_WIDTH = vau_pkg::DataWidthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // command, a_x, a_y, a_z, b_x, b_y, b_z, scalar (lowest bit up), zero pad
  input  wire logic [8*((7*DATA_WIDTH+10)/8)-1:0]  s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // r_x, r_y, r_z, dot_value, test_flag, divide_error (lowest bit up), zero pad
  output logic [8*((4*DATA_WIDTH+9)/8)-1:0]        m_axis_tdata
);

  localparam int W        = DATA_WIDTH;
  localparam int VL       = vau_pkg::VecLen;
  localparam int CmdW     = 3;
  localparam int OffA     = CmdW;
  localparam int OffB     = CmdW + VL * W;
  localparam int OffK     = CmdW + 2 * VL * W;
  localparam int OutTdW   = 8 * ((4 * W + 9) / 8);
  localparam int LaneLat  = W + 1;

  vau_pkg::cmd_e        cmd;
  logic [W-1:0]         a_v [VL];
  logic [W-1:0]         b_v [VL];
  logic [W-1:0]         scalar;

  logic [W-1:0]         lane_res   [VL];
  logic [W-1:0]         lane_dot   [VL];
  vau_pkg::lane_flags_t lane_flags [VL];

  logic [W-1:0]         r_v [VL];
  logic [W-1:0]         dot_value;
  logic                 test_flag;
  logic                 divide_error;

  logic                 pipe_en;
  logic [LaneLat-1:0]   vld_q;
  logic                 out_vld_q;

  assign cmd    = vau_pkg::cmd_e'(s_axis_tdata[CmdW-1:0]);
  assign scalar = s_axis_tdata[OffK +: W];

  for (genvar i = 0; i < VL; i++) begin : g_unpack
    assign a_v[i] = s_axis_tdata[OffA + i*W +: W];
    assign b_v[i] = s_axis_tdata[OffB + i*W +: W];
  end

  // Advance everything when the output register is free or being drained
  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q     <= {vld_q[LaneLat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[LaneLat-1];
    end
  end

  for (genvar i = 0; i < VL; i++) begin : g_lane
    vau_lane #(
      .DATA_WIDTH (W)
    ) u_lane (
      .clk_i      (clk_i),
      .en_i       (pipe_en),
      .cmd_i      (cmd),
      .a_c_i      (a_v[i]),
      .a_n_i      (a_v[(i+1)%VL]),
      .a_p_i      (a_v[(i+2)%VL]),
      .b_c_i      (b_v[i]),
      .b_n_i      (b_v[(i+1)%VL]),
      .b_p_i      (b_v[(i+2)%VL]),
      .scalar_i   (scalar),
      .res_o      (lane_res[i]),
      .dot_term_o (lane_dot[i]),
      .flags_o    (lane_flags[i])
    );
  end

  vau_merge #(
    .DATA_WIDTH (W)
  ) u_merge (
    .clk_i          (clk_i),
    .en_i           (pipe_en),
    .res_i          (lane_res),
    .dot_term_i     (lane_dot),
    .flags_i        (lane_flags),
    .r_o            (r_v),
    .dot_value_o    (dot_value),
    .test_flag_o    (test_flag),
    .divide_error_o (divide_error)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutTdW'({divide_error, test_flag, dot_value, r_v[2], r_v[1], r_v[0]});

  // A zero-divisor beat carries nothing but the error flag
  a_div_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && divide_error) |->
      (r_v[0] == '0 && r_v[1] == '0 && r_v[2] == '0 && dot_value == '0 && !test_flag))
    else $error("divide error beat has nonzero payload");

  // A test result never comes with a vector or dot value
  a_test_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && test_flag) |->
      (r_v[0] == '0 && r_v[1] == '0 && r_v[2] == '0 && dot_value == '0 && !divide_error))
    else $error("test flag beat has nonzero payload");

  // A beat leaving the lanes while the output is stalled must not be lost
  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(vld_q)))
    else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// File: tb/tb_vector3_integer_alu.sv
`timescale 1ns / 100ps

module tb_vector3_integer_alu;

  localparam int DW        = 16;
  localparam int IN_W      = 8 * ((7 * DW + 10) / 8);
  localparam int OUT_W     = 8 * ((4 * DW + 9) / 8);
  localparam int LATENCY   = DW + 2;
  localparam int PHASE_OPS = 640;
  localparam int MAX_CYCLES = 300000;

  // Input beat fields, listed from the highest bits down, so the command sits lowest
  typedef struct packed {
    logic [DW-1:0] scalar;
    logic [DW-1:0] b_z;
    logic [DW-1:0] b_y;
    logic [DW-1:0] b_x;
    logic [DW-1:0] a_z;
    logic [DW-1:0] a_y;
    logic [DW-1:0] a_x;
    vau_pkg::cmd_e cmd;
  } alu_op_t;

  // Output beat fields, listed from the highest bits down, so r_x sits lowest
  typedef struct packed {
    logic          divide_error;
    logic          test_flag;
    logic [DW-1:0] dot_value;
    logic [DW-1:0] r_z;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_x;
  } alu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  alu_op_t     op_pending[$];
  alu_result_t expected_results[$];
  alu_op_t     op_on_bus;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatch_count;
  int          results_checked;
  int          beats_sent;
  int          cmd_count[8];
  int          div_by_zero_count;
  int          min_by_neg_one_count;
  int          cycle_count;

  vector3_integer_alu #(
    .DATA_WIDTH(DW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // command, a_x, a_y, a_z, b_x, b_y, b_z, scalar (lowest bit up), zero pad
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // r_x, r_y, r_z, dot_value, test_flag, divide_error (lowest bit up), zero pad
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic alu_result_t compute_alu_result(alu_op_t op);
    alu_result_t res;
    int ax, ay, az, bx, by, bz, k;
    ax = int'($signed(op.a_x));
    ay = int'($signed(op.a_y));
    az = int'($signed(op.a_z));
    bx = int'($signed(op.b_x));
    by = int'($signed(op.b_y));
    bz = int'($signed(op.b_z));
    k  = int'($signed(op.scalar));
    res = '0;
    // 32-bit int math wraps modulo 2^32, so the low 16 bits stay exact
    case (op.cmd)
      vau_pkg::CMD_CROSS: begin
        res.r_x = DW'(ay * bz - az * by);
        res.r_y = DW'(az * bx - ax * bz);
        res.r_z = DW'(ax * by - ay * bx);
      end
      vau_pkg::CMD_DOT:   res.dot_value = DW'(ax * bx + ay * by + az * bz);
      vau_pkg::CMD_ADD: begin
        res.r_x = DW'(ax + bx);
        res.r_y = DW'(ay + by);
        res.r_z = DW'(az + bz);
      end
      vau_pkg::CMD_SUB: begin
        res.r_x = DW'(ax - bx);
        res.r_y = DW'(ay - by);
        res.r_z = DW'(az - bz);
      end
      vau_pkg::CMD_SCALE: begin
        res.r_x = DW'(ax * k);
        res.r_y = DW'(ay * k);
        res.r_z = DW'(az * k);
      end
      vau_pkg::CMD_DIV: begin
        if (k == 0) begin
          res.divide_error = 1'b1;
        end else begin
          // int division truncates toward zero; min / -1 wraps on the cut
          res.r_x = DW'(ax / k);
          res.r_y = DW'(ay / k);
          res.r_z = DW'(az / k);
        end
      end
      vau_pkg::CMD_EQ: begin
        res.test_flag = (op.a_x == op.b_x) && (op.a_y == op.b_y) && (op.a_z == op.b_z);
      end
      default:   res.test_flag = (op.a_x == '0) && (op.a_y == '0) && (op.a_z == '0);
    endcase
    return res;
  endfunction

  function automatic alu_op_t make_op(vau_pkg::cmd_e cmd, logic [DW-1:0] ax,
                                      logic [DW-1:0] ay,
                                      logic [DW-1:0] az, logic [DW-1:0] bx,
                                      logic [DW-1:0] by, logic [DW-1:0] bz,
                                      logic [DW-1:0] k);
    alu_op_t op;
    op.cmd = cmd;
    op.a_x = ax;
    op.a_y = ay;
    op.a_z = az;
    op.b_x = bx;
    op.b_y = by;
    op.b_z = bz;
    op.scalar = k;
    return op;
  endfunction

  // Lean toward the corners of the range, keep plenty of full-range words
  function automatic logic [DW-1:0] pick_word();
    logic [DW-1:0] w;
    case ($urandom_range(0, 9))
      0:       w = 16'h8000;
      1:       w = 16'h7fff;
      2:       w = 16'h0000;
      3:       w = 16'hffff;
      4, 5:    w = DW'(int'($urandom_range(0, 20)) - 10);
      default: w = DW'($urandom);
    endcase
    return w;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    op = make_op(vau_pkg::cmd_e'($urandom_range(0, 7)), pick_word(), pick_word(),
                 pick_word(), pick_word(), pick_word(), pick_word(), pick_word());
    case (op.cmd)
      vau_pkg::CMD_EQ: begin
        if ($urandom_range(0, 2) != 0) begin
          op.b_x = op.a_x;
          op.b_y = op.a_y;
          op.b_z = op.a_z;
          // near miss: one bit off in one component
          if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 2))
              0:       op.b_x[$urandom_range(0, DW-1)] ^= 1'b1;
              1:       op.b_y[$urandom_range(0, DW-1)] ^= 1'b1;
              default: op.b_z[$urandom_range(0, DW-1)] ^= 1'b1;
            endcase
          end
        end
      end
      vau_pkg::CMD_ZERO: begin
        if ($urandom_range(0, 2) != 0) begin
          op.a_x = '0;
          op.a_y = '0;
          op.a_z = '0;
          if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 2))
              0:       op.a_x = DW'(1) << $urandom_range(0, DW-1);
              1:       op.a_y = DW'(1) << $urandom_range(0, DW-1);
              default: op.a_z = DW'(1) << $urandom_range(0, DW-1);
            endcase
          end
        end
      end
      vau_pkg::CMD_DIV: begin
        case ($urandom_range(0, 5))
          0: op.scalar = '0;
          1: begin
            op.scalar = '1;
            op.a_y = 16'h8000;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    if (mismatch_count < 30)
      $display("%0t: result %0d %s got %h want %h", $realtime, results_checked, what, got,
               want);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    while (op_pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Sender: hold the beat until taken, then advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    alu_op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (op_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op = op_pending.pop_front();
        op_on_bus     <= op;
        s_axis_tdata  <= IN_W'(op);
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input beats, check on output beats
  always @(posedge clk_i) begin
    alu_result_t got;
    alu_result_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(compute_alu_result(op_on_bus));
      beats_sent++;
      cmd_count[op_on_bus.cmd]++;
      if (op_on_bus.cmd == vau_pkg::CMD_DIV && op_on_bus.scalar == '0)
        div_by_zero_count++;
      if (op_on_bus.cmd == vau_pkg::CMD_DIV && op_on_bus.scalar == '1 &&
          (op_on_bus.a_x == 16'h8000 || op_on_bus.a_y == 16'h8000 ||
           op_on_bus.a_z == 16'h8000))
        min_by_neg_one_count++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = alu_result_t'(m_axis_tdata[$bits(alu_result_t)-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", got.r_x, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.r_x !== want.r_x) report_mismatch("r_x", got.r_x, want.r_x);
        if (got.r_y !== want.r_y) report_mismatch("r_y", got.r_y, want.r_y);
        if (got.r_z !== want.r_z) report_mismatch("r_z", got.r_z, want.r_z);
        if (got.dot_value !== want.dot_value)
          report_mismatch("dot_value", got.dot_value, want.dot_value);
        if (got.test_flag !== want.test_flag)
          report_mismatch("test_flag", DW'(got.test_flag), DW'(want.test_flag));
        if (got.divide_error !== want.divide_error)
          report_mismatch("divide_error", DW'(got.divide_error), DW'(want.divide_error));
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0d results still outstanding after %0d cycles", expected_results.size(),
               cycle_count);
      $display("vector3_integer_alu: mismatch");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 38;
    recv_idle_pct = 79;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners and special cases of every command
    op_pending.push_back(make_op(vau_pkg::CMD_CROSS, 16'h7fff, 16'h8000, 16'h7fff,
                                 16'h8000, 16'h7fff, 16'h8000, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_CROSS, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
                                 16'd6, 16'h8000));
    op_pending.push_back(make_op(vau_pkg::CMD_DOT, 16'h7fff, 16'h7fff, 16'h7fff,
                                 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff));
    op_pending.push_back(make_op(vau_pkg::CMD_DOT, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 16'h7fff, 16'hffff, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_ADD, 16'h7fff, 16'h8000, 16'hffff,
                                 16'h0001, 16'h8000, 16'h0001, 16'h7fff));
    op_pending.push_back(make_op(vau_pkg::CMD_SUB, 16'h8000, 16'h0000, 16'h7fff,
                                 16'h0001, 16'h8000, 16'hffff, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_SCALE, 16'h8000, 16'h7fff, 16'h0001,
                                 16'h1234, 16'h0000, 16'hffff, 16'hffff));
    op_pending.push_back(make_op(vau_pkg::CMD_SCALE, 16'h7fff, 16'h8000, 16'h0003,
                                 16'h0000, 16'h0000, 16'h0000, 16'h7fff));
    op_pending.push_back(make_op(vau_pkg::CMD_SCALE, 16'h7fff, 16'h8000, 16'h0003,
                                 16'h0000, 16'h0000, 16'h0000, 16'h8000));
    op_pending.push_back(make_op(vau_pkg::CMD_DIV, 16'hfff9, 16'h0007, 16'h7fff,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0002));
    op_pending.push_back(make_op(vau_pkg::CMD_DIV, 16'h1234, 16'h8000, 16'h7fff,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_DIV, 16'h8000, 16'h7fff, 16'h0001,
                                 16'h0000, 16'h0000, 16'h0000, 16'hffff));
    op_pending.push_back(make_op(vau_pkg::CMD_DIV, 16'h8000, 16'h7fff, 16'hffff,
                                 16'h0000, 16'h0000, 16'h0000, 16'h8000));
    op_pending.push_back(make_op(vau_pkg::CMD_DIV, 16'h7fff, 16'hfffd, 16'h0005,
                                 16'hffff, 16'hffff, 16'hffff, 16'hfffd));
    op_pending.push_back(make_op(vau_pkg::CMD_EQ, 16'h8000, 16'h7fff, 16'hffff,
                                 16'h8000, 16'h7fff, 16'hffff, 16'h8000));
    op_pending.push_back(make_op(vau_pkg::CMD_EQ, 16'h0001, 16'h0002, 16'h0003,
                                 16'h0001, 16'h0002, 16'h0007, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_EQ, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0000, 16'h0000, 16'h0000, 16'hffff));
    op_pending.push_back(make_op(vau_pkg::CMD_ZERO, 16'h0000, 16'h0000, 16'h0000,
                                 16'hffff, 16'h8000, 16'h7fff, 16'h7fff));
    op_pending.push_back(make_op(vau_pkg::CMD_ZERO, 16'h0001, 16'h0000, 16'h0000,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_ZERO, 16'h0000, 16'h0000, 16'h8000,
                                 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    op_pending.push_back(make_op(vau_pkg::CMD_ZERO, 16'hffff, 16'hffff, 16'hffff,
                                 16'hffff, 16'hffff, 16'hffff, 16'hffff));

    for (int i = 0; i < PHASE_OPS; i++)
      op_pending.push_back(random_op());
    wait_drained();

    // Swap the stall rates; the sender held off until the pipe drained
    send_idle_pct = 79;
    recv_idle_pct = 38;
    for (int i = 0; i < PHASE_OPS; i++)
      op_pending.push_back(random_op());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < PHASE_OPS; i++)
      op_pending.push_back(random_op());
    wait_drained();

    // Catch any stray beat past the pipeline depth
    repeat (2 * LATENCY + 10) @(posedge clk_i);

    $display("checked %0d results from %0d beats, commands 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             results_checked, beats_sent, cmd_count[0], cmd_count[1], cmd_count[2],
             cmd_count[3], cmd_count[4], cmd_count[5], cmd_count[6], cmd_count[7]);
    $display("divides by zero: %0d, most negative over minus one: %0d, mismatches: %0d",
             div_by_zero_count, min_by_neg_one_count, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("vector3_integer_alu: match");
    end else begin
      $display("vector3_integer_alu: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/vau_pkg.sv
hdl/vau_lane.sv
hdl/vau_merge.sv
hdl/vector3_integer_alu.sv
tb/tb_vector3_integer_alu.sv
